### hw/rtl/z_sort_bucket_select_macros.svh
// ----------------------------------------------------------------------------
// Z-sort bucket select: assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef Z_SORT_BUCKET_SELECT_MACROS_SVH
`define Z_SORT_BUCKET_SELECT_MACROS_SVH

// The consequent must hold in every cycle in which the antecedent holds.
`define ZSB_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The condition must never hold.
`define ZSB_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

### hw/rtl/zsb_pkg.sv
// ----------------------------------------------------------------------------
// Z-sort bucket select: shared package
// Field widths, codes, register map and the configuration bundle that the
// top level hands to the back end.
// ----------------------------------------------------------------------------
package zsb_pkg;

    localparam int DEPTH_W = 32;
    localparam int SUM_W   = 34;
    localparam int SIZE_W  = 13;
    localparam int IDX_W   = 12;
    localparam int RULE_W  = 2;
    localparam int KIND_W  = 2;
    localparam int FRAC_W  = 16;
    localparam int PROD_W  = DEPTH_W + SIZE_W;

    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 32;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [SIZE_W-1:0]  SMALL_SCALE     = 13'd1000;
    localparam logic [DEPTH_W:0]   SMALL_RANGE_MAX = 33'd65;

    localparam logic [RULE_W-1:0] RULE_AVG = 2'd1;
    localparam logic [RULE_W-1:0] RULE_MIN = 2'd2;
    localparam logic [RULE_W-1:0] RULE_MAX = 2'd3;

    localparam logic [KIND_W-1:0] KIND_POINT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LINE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TRI   = 2'd2;

    localparam logic [SIZE_W-1:0] BUCKET_COUNT_RESET = 13'd256;

    typedef enum logic [1:0] {
        REG_DEPTH_MIN    = 2'd0,
        REG_DEPTH_MAX    = 2'd1,
        REG_BUCKET_COUNT = 2'd2,
        REG_DEPTH_RULE   = 2'd3
    } zsb_reg_t;

    // Depths are carried in offset-binary form (sign bit flipped), so all
    // comparisons and sums downstream are unsigned.
    typedef struct packed {
        logic [DEPTH_W-1:0] zmin_u;
        logic [DEPTH_W-1:0] zmax_u;
        logic [DEPTH_W-1:0] rng;
        logic               narrow;
        logic [SIZE_W-1:0]  size;
    } zsb_cfg_t;

endpackage

### hw/rtl/zsb_queue.sv
// ----------------------------------------------------------------------------
// Z-sort bucket select: word queue
// Small first-in first-out queue of words with registered storage and the
// oldest word presented on the read side.
// ----------------------------------------------------------------------------
module zsb_queue #(
    parameter int DEPTH = 4,
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### hw/rtl/zsb_front.sv
// ----------------------------------------------------------------------------
// Z-sort bucket select: front end
// Accepts primitives and reduces the vertex depths to one word: three times
// the representative depth, or the plain three-vertex sum for a triangle
// average, both in offset-binary form.
// ----------------------------------------------------------------------------
module zsb_front import zsb_pkg::*; (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic        [KIND_W-1:0]  prim_kind,
    input  logic signed [DEPTH_W-1:0] depth_a,
    input  logic signed [DEPTH_W-1:0] depth_b,
    input  logic signed [DEPTH_W-1:0] depth_c,
    input  logic        [RULE_W-1:0]  depth_rule,
    input  logic                      mid_full,
    output logic                      mid_wr,
    output logic        [SUM_W-1:0]   mid_data
);

    logic               valid_reg;
    logic               valid_next;
    logic [SUM_W-1:0]   sum_reg;
    logic [SUM_W-1:0]   sum_next;
    logic               accept;
    logic [DEPTH_W-1:0] a_u;
    logic [DEPTH_W-1:0] b_u;
    logic [DEPTH_W-1:0] c_u;
    logic [DEPTH_W:0]   ab_sum;
    logic [DEPTH_W-1:0] min_ab;
    logic [DEPTH_W-1:0] max_ab;
    logic [DEPTH_W-1:0] min_abc;
    logic [DEPTH_W-1:0] max_abc;
    logic [DEPTH_W-1:0] rep_u;
    logic               tri_avg;

    assign full     = valid_reg && mid_full;
    assign accept   = push && !full;
    assign mid_wr   = valid_reg && !mid_full;
    assign mid_data = sum_reg;

    assign a_u = {~depth_a[DEPTH_W-1], depth_a[DEPTH_W-2:0]};
    assign b_u = {~depth_b[DEPTH_W-1], depth_b[DEPTH_W-2:0]};
    assign c_u = {~depth_c[DEPTH_W-1], depth_c[DEPTH_W-2:0]};

    assign ab_sum  = {1'b0, a_u} + {1'b0, b_u};
    assign min_ab  = (b_u < a_u) ? b_u : a_u;
    assign max_ab  = (a_u < b_u) ? b_u : a_u;
    assign min_abc = (c_u < min_ab) ? c_u : min_ab;
    assign max_abc = (max_ab < c_u) ? c_u : max_ab;

    always_comb
    begin
        rep_u   = a_u;
        tri_avg = 1'b0;
        unique case (prim_kind)
            KIND_LINE:
            begin
                unique case (depth_rule)
                    RULE_MIN: rep_u = min_ab;
                    RULE_MAX: rep_u = max_ab;
                    default:  rep_u = ab_sum[DEPTH_W:1];
                endcase
            end
            KIND_TRI:
            begin
                unique case (depth_rule)
                    RULE_MIN: rep_u = min_abc;
                    RULE_MAX: rep_u = max_abc;
                    default:  tri_avg = 1'b1;
                endcase
            end
            default: rep_u = a_u;
        endcase
    end

    always_comb
    begin
        if (tri_avg)
        begin
            sum_next = SUM_W'(a_u) + SUM_W'(b_u) + SUM_W'(c_u);
        end
        else
        begin
            sum_next = SUM_W'({rep_u, 1'b0}) + SUM_W'(rep_u);
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (mid_wr)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sum_reg <= sum_next;
        end
    end

endmodule

### hw/rtl/zsb_back.sv
// ----------------------------------------------------------------------------
// Z-sort bucket select: back end
// Free-running pipeline: exact division by three, near-bound offset, scale
// multiply, bit-per-stage division by the depth range and final clamp.
// Items are issued only when the result queue has room reserved for them.
// ----------------------------------------------------------------------------
module zsb_back import zsb_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  zsb_cfg_t          cfg,
    input  logic              mid_empty,
    input  logic [SUM_W-1:0]  mid_data,
    output logic              mid_rd,
    output logic              out_wr,
    output logic [IDX_W-1:0]  out_data,
    input  logic              out_pop
);

    localparam int D3_BITS    = 7;
    localparam int D3_STAGES  = (SUM_W + D3_BITS - 1) / D3_BITS;
    localparam int D3_W       = D3_STAGES * D3_BITS;
    localparam int DIV_STAGES = SIZE_W;
    localparam int RES_W      = $clog2(OUT_DEPTH + 1);

    typedef struct packed {
        logic [D3_W-1:0] u;
        logic [D3_W-1:0] q;
        logic [1:0]      r;
    } d3_t;

    typedef struct packed {
        logic [DEPTH_W-1:0] r;
        logic [SIZE_W-1:0]  nlow;
        logic [SIZE_W-1:0]  q;
        logic               fix;
    } dv_t;

    function automatic logic [D3_BITS+1:0] div3_chunk(input logic [1:0] r_in,
                                                      input logic [D3_BITS-1:0] bits);
        logic [1:0]         r;
        logic [2:0]         t;
        logic [D3_BITS-1:0] q;
        r = r_in;
        q = '0;
        for (int i = D3_BITS - 1; i >= 0; i--)
        begin
            t = {r, bits[i]};
            if (t >= 3'd3)
            begin
                q[i] = 1'b1;
                t    = t - 3'd3;
            end
            r = t[1:0];
        end
        return {r, q};
    endfunction

    function automatic d3_t d3_advance(input d3_t x);
        logic [D3_BITS+1:0] chunk;
        d3_t                y;
        chunk = div3_chunk(x.r, x.u[D3_W-1 -: D3_BITS]);
        y.u   = x.u << D3_BITS;
        y.q   = {x.q[D3_W-D3_BITS-1:0], chunk[D3_BITS-1:0]};
        y.r   = chunk[D3_BITS+1:D3_BITS];
        return y;
    endfunction

    function automatic dv_t dv_advance(input dv_t x, input logic [DEPTH_W-1:0] rng);
        logic [DEPTH_W:0] t;
        dv_t              y;
        t      = {x.r, x.nlow[SIZE_W-1]};
        y      = x;
        y.nlow = x.nlow << 1;
        if (!x.fix)
        begin
            if (t >= {1'b0, rng})
            begin
                t   = t - {1'b0, rng};
                y.q = {x.q[SIZE_W-2:0], 1'b1};
            end
            else
            begin
                y.q = {x.q[SIZE_W-2:0], 1'b0};
            end
        end
        y.r = t[DEPTH_W-1:0];
        return y;
    endfunction

    logic [RES_W-1:0]      res_reg;
    logic [RES_W-1:0]      res_next;
    logic                  issue;

    d3_t                   d3_head;
    d3_t                   d3_reg [D3_STAGES];
    logic [D3_STAGES-1:0]  d3_vld_reg;

    logic [DEPTH_W-1:0]    rep_u;
    logic [DEPTH_W-1:0]    off_next;
    logic                  ge_next;
    logic [DEPTH_W-1:0]    off_reg;
    logic                  ge_reg;
    logic                  off_vld_reg;

    logic [SIZE_W-1:0]     mult;
    logic [PROD_W-1:0]     prod_reg;
    logic                  fix_reg;
    logic                  prod_vld_reg;

    logic [SIZE_W-1:0]     small_sat;
    dv_t                   dv_head;
    dv_t                   dv_reg [DIV_STAGES];
    logic [DIV_STAGES-1:0] dv_vld_reg;

    logic [SIZE_W-1:0]     cand;
    logic [SIZE_W-1:0]     bucket;

    // Issue and reservation of result queue space.
    assign issue  = !mid_empty && (res_reg < RES_W'(OUT_DEPTH));
    assign mid_rd = issue;

    always_comb
    begin
        res_next = res_reg;
        if (issue && !out_pop)
        begin
            res_next = res_reg + 1'b1;
        end
        else if (out_pop && !issue)
        begin
            res_next = res_reg - 1'b1;
        end
    end

    // Division by three, a few quotient bits per stage.
    always_comb
    begin
        d3_head.u = D3_W'(mid_data);
        d3_head.q = '0;
        d3_head.r = '0;
    end

    // Offset from the near bound and the far-bound saturation test.
    assign rep_u    = d3_reg[D3_STAGES-1].q[DEPTH_W-1:0];
    assign off_next = (rep_u >= cfg.zmin_u) ? rep_u - cfg.zmin_u : '0;
    assign ge_next  = (rep_u >= cfg.zmax_u);

    assign mult = cfg.narrow ? SMALL_SCALE : cfg.size;

    // Division by the range, one quotient bit per stage.
    assign small_sat = (|prod_reg[PROD_W-1:FRAC_W+SIZE_W]) ? '1
                                                          : prod_reg[FRAC_W+SIZE_W-1:FRAC_W];

    always_comb
    begin
        dv_head.r    = prod_reg[PROD_W-1:SIZE_W];
        dv_head.nlow = prod_reg[SIZE_W-1:0];
        dv_head.q    = cfg.narrow ? small_sat : '1;
        dv_head.fix  = fix_reg;
    end

    // Final clamp to the bucket count.
    assign cand = dv_reg[DIV_STAGES-1].q;

    always_comb
    begin
        if (cfg.size == '0)
        begin
            bucket = '0;
        end
        else if (cand > cfg.size - 1'b1)
        begin
            bucket = cfg.size - 1'b1;
        end
        else
        begin
            bucket = cand;
        end
    end

    assign out_wr   = dv_vld_reg[DIV_STAGES-1];
    assign out_data = bucket[IDX_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg      <= '0;
            d3_vld_reg   <= '0;
            off_vld_reg  <= 1'b0;
            prod_vld_reg <= 1'b0;
            dv_vld_reg   <= '0;
        end
        else
        begin
            res_reg      <= res_next;
            d3_vld_reg   <= {d3_vld_reg[D3_STAGES-2:0], issue};
            off_vld_reg  <= d3_vld_reg[D3_STAGES-1];
            prod_vld_reg <= off_vld_reg;
            dv_vld_reg   <= {dv_vld_reg[DIV_STAGES-2:0], prod_vld_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        d3_reg[0] <= d3_advance(d3_head);
        for (int s = 1; s < D3_STAGES; s++)
        begin
            d3_reg[s] <= d3_advance(d3_reg[s-1]);
        end
        off_reg   <= off_next;
        ge_reg    <= ge_next;
        prod_reg  <= PROD_W'(off_reg) * PROD_W'(mult);
        fix_reg   <= cfg.narrow || ge_reg;
        dv_reg[0] <= dv_advance(dv_head, cfg.rng);
        for (int k = 1; k < DIV_STAGES; k++)
        begin
            dv_reg[k] <= dv_advance(dv_reg[k-1], cfg.rng);
        end
    end

endmodule

### hw/rtl/z_sort_bucket_select.sv
// ----------------------------------------------------------------------------
// Z-sort bucket select: top level
// Picks the order-table bucket of a point, line or triangle from its vertex
// depths, the configured depth rule, depth bounds and bucket count.
//
//   Channel   Handshake             Words
//   config    psel/penable/pwrite   depth_min, depth_max, bucket_count, depth_rule
//   input     push / full           prim_kind, depth_a, depth_b, depth_c
//   result    pop / empty           bucket_index
//
// One primitive is accepted per cycle while full is low, and one bucket is
// delivered per cycle while empty is low. A result passes the front-end
// register, the middle queue, the five division-by-three stages, the offset
// and product registers and the thirteen range-division stages. The result
// queue holds 32 words, and issue into the back end stops only when all 32
// places are taken by waiting or in-flight words. Reset is asynchronous and
// active low; it empties both queues and loads the register reset values.
// ----------------------------------------------------------------------------
`include "z_sort_bucket_select_macros.svh"

module z_sort_bucket_select import zsb_pkg::*; #(
    parameter int MAX_BUCKETS = 4096
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic        [APB_ADDR_W-1:0] paddr,
    input  logic        [APB_DATA_W-1:0] pwdata,
    output logic        [APB_DATA_W-1:0] prdata,
    output logic                         pready,
    input  logic                         push,
    output logic                         full,
    input  logic        [KIND_W-1:0]     prim_kind,
    input  logic signed [DEPTH_W-1:0]    depth_a,
    input  logic signed [DEPTH_W-1:0]    depth_b,
    input  logic signed [DEPTH_W-1:0]    depth_c,
    output logic                         empty,
    input  logic                         pop,
    output logic        [IDX_W-1:0]      bucket_index
);

    logic signed [DEPTH_W-1:0] depth_min_reg;
    logic signed [DEPTH_W-1:0] depth_max_reg;
    logic        [SIZE_W-1:0]  bucket_count_reg;
    logic        [RULE_W-1:0]  depth_rule_reg;
    logic                      cfg_wr;
    zsb_reg_t                  reg_sel;
    logic signed [DEPTH_W:0]   range_s;
    zsb_cfg_t                  cfg;

    logic                      mid_wr;
    logic        [SUM_W-1:0]   mid_wdata;
    logic                      mid_full;
    logic                      mid_rd;
    logic        [SUM_W-1:0]   mid_rdata;
    logic                      mid_empty;

    logic                      ofifo_wr;
    logic        [IDX_W-1:0]   ofifo_wdata;
    logic                      ofifo_full;
    logic                      out_pop;
    logic                      bucket_ok;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = zsb_reg_t'(paddr[3:2]);
    assign out_pop = pop && !empty;

    always_comb
    begin
        unique case (reg_sel)
            REG_DEPTH_MIN:    prdata = depth_min_reg;
            REG_DEPTH_MAX:    prdata = depth_max_reg;
            REG_BUCKET_COUNT: prdata = APB_DATA_W'(bucket_count_reg);
            REG_DEPTH_RULE:   prdata = APB_DATA_W'(depth_rule_reg);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_min_reg    <= '0;
            depth_max_reg    <= '0;
            bucket_count_reg <= BUCKET_COUNT_RESET;
            depth_rule_reg   <= RULE_AVG;
        end
        else if (cfg_wr)
        begin
            unique case (reg_sel)
                REG_DEPTH_MIN:    depth_min_reg    <= pwdata;
                REG_DEPTH_MAX:    depth_max_reg    <= pwdata;
                REG_BUCKET_COUNT: bucket_count_reg <= pwdata[SIZE_W-1:0];
                REG_DEPTH_RULE:   depth_rule_reg   <= pwdata[RULE_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        cfg.zmin_u = {~depth_min_reg[DEPTH_W-1], depth_min_reg[DEPTH_W-2:0]};
        cfg.zmax_u = {~depth_max_reg[DEPTH_W-1], depth_max_reg[DEPTH_W-2:0]};
        range_s    = $signed({1'b0, cfg.zmax_u}) - $signed({1'b0, cfg.zmin_u});
        cfg.narrow = (range_s <= $signed(SMALL_RANGE_MAX));
        cfg.rng    = range_s[DEPTH_W-1:0];
        if (int'(bucket_count_reg) > MAX_BUCKETS)
        begin
            cfg.size = SIZE_W'(MAX_BUCKETS);
        end
        else
        begin
            cfg.size = bucket_count_reg;
        end
    end

    zsb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .prim_kind  (prim_kind),
        .depth_a    (depth_a),
        .depth_b    (depth_b),
        .depth_c    (depth_c),
        .depth_rule (depth_rule_reg),
        .mid_full   (mid_full),
        .mid_wr     (mid_wr),
        .mid_data   (mid_wdata)
    );

    zsb_queue #(
        .DEPTH (MID_DEPTH),
        .WIDTH (SUM_W)
    ) u_mid_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (mid_wr),
        .wr_data (mid_wdata),
        .full    (mid_full),
        .rd_en   (mid_rd),
        .rd_data (mid_rdata),
        .empty   (mid_empty)
    );

    zsb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .mid_empty (mid_empty),
        .mid_data  (mid_rdata),
        .mid_rd    (mid_rd),
        .out_wr    (ofifo_wr),
        .out_data  (ofifo_wdata),
        .out_pop   (out_pop)
    );

    zsb_queue #(
        .DEPTH (OUT_DEPTH),
        .WIDTH (IDX_W)
    ) u_out_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (ofifo_wr),
        .wr_data (ofifo_wdata),
        .full    (ofifo_full),
        .rd_en   (pop),
        .rd_data (bucket_index),
        .empty   (empty)
    );

    assign bucket_ok = (cfg.size == '0) ? (ofifo_wdata == '0)
                                        : ({1'b0, ofifo_wdata} < cfg.size);

    `ZSB_ASSERT_NEVER(a_no_result_overflow, clk, rst_n, ofifo_wr && ofifo_full, "result queue overflow")
    `ZSB_ASSERT_NEVER(a_no_mid_underflow, clk, rst_n, mid_rd && mid_empty, "issue from empty queue")
    `ZSB_ASSERT_IMPLIES(a_bucket_in_range, clk, rst_n, ofifo_wr, bucket_ok, "bucket out of range")

endmodule

### bench/zsb_bucket_checker.sv
// ----------------------------------------------------------------------------
// Z-sort bucket select: bucket checker
// Watches the register port and both word channels of the bucket selector.
// It keeps its own copy of the depth bounds, bucket count and depth rule,
// works out the expected bucket of every accepted primitive, and compares
// each delivered word, in order, against the oldest expected bucket.
// ----------------------------------------------------------------------------
module zsb_bucket_checker import zsb_pkg::*; #(
    parameter int MAX_BUCKETS = 4096
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic        [APB_ADDR_W-1:0] paddr,
    input  logic        [APB_DATA_W-1:0] pwdata,
    input  logic                         pready,
    input  logic                         push,
    input  logic                         full,
    input  logic        [KIND_W-1:0]     prim_kind,
    input  logic signed [DEPTH_W-1:0]    depth_a,
    input  logic signed [DEPTH_W-1:0]    depth_b,
    input  logic signed [DEPTH_W-1:0]    depth_c,
    input  logic                         empty,
    input  logic                         pop,
    input  logic        [IDX_W-1:0]      bucket_index,
    output int                           fail_count,
    output int                           words_waiting
);

    localparam longint NARROW_SPAN_MAX   = 65;
    localparam longint NARROW_SPAN_SCALE = 1000;
    localparam longint Q16_ONE           = 65536;

    logic signed [DEPTH_W-1:0] near_bound;
    logic signed [DEPTH_W-1:0] far_bound;
    logic        [SIZE_W-1:0]  bucket_total;
    logic        [RULE_W-1:0]  rule_sel;
    logic        [IDX_W-1:0]   expected_buckets[$];

    initial fail_count = 0;

    task automatic report_mismatch(input string what);
        $display("[%0t] bucket check: %s", $time, what);
        fail_count++;
    endtask

    function automatic longint floor_quot(input longint num, input longint den);
        longint q;
        q = num / den;
        if (num < 0 && q * den != num)
            q = q - 1;
        return q;
    endfunction

    function automatic logic [IDX_W-1:0] predict_bucket(
        input logic        [KIND_W-1:0]  kind,
        input logic signed [DEPTH_W-1:0] a,
        input logic signed [DEPTH_W-1:0] b,
        input logic signed [DEPTH_W-1:0] c
    );
        longint za, zb, zc, zlo, zhi, rep, offset, span, size, idx;
        za   = a;
        zb   = b;
        zc   = c;
        zlo  = near_bound;
        zhi  = far_bound;
        size = longint'(bucket_total);
        if (size > MAX_BUCKETS)
            size = MAX_BUCKETS;

        rep = za;
        if (kind == KIND_LINE || kind == KIND_TRI)
        begin
            case (rule_sel)
                RULE_MIN:
                begin
                    if (zb < rep) rep = zb;
                    if (kind == KIND_TRI && zc < rep) rep = zc;
                end
                RULE_MAX:
                begin
                    if (zb > rep) rep = zb;
                    if (kind == KIND_TRI && zc > rep) rep = zc;
                end
                default:
                    rep = (kind == KIND_TRI) ? floor_quot(za + zb + zc, 3)
                                             : floor_quot(za + zb, 2);
            endcase
        end

        offset = rep - zlo;
        if (offset < 0)
            offset = 0;
        span = zhi - zlo;
        if (span <= NARROW_SPAN_MAX)
            idx = (offset * NARROW_SPAN_SCALE) / Q16_ONE;
        else
            idx = (offset * size) / span;

        if (size == 0)
            idx = 0;
        else if (idx > size - 1)
            idx = size - 1;
        return idx[IDX_W-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        logic [IDX_W-1:0] want;
        if (!rst_n)
        begin
            near_bound   <= '0;
            far_bound    <= '0;
            bucket_total <= BUCKET_COUNT_RESET;
            rule_sel     <= RULE_AVG;
            expected_buckets.delete();
            words_waiting <= 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_buckets.size() == 0)
                    report_mismatch($sformatf("word with nothing expected, bucket_index %0d",
                                              bucket_index));
                else
                begin
                    want = expected_buckets.pop_front();
                    if (bucket_index !== want)
                        report_mismatch($sformatf("bucket_index %0d, expected %0d",
                                                  bucket_index, want));
                end
            end
            if (push && !full)
                expected_buckets.push_back(predict_bucket(prim_kind, depth_a, depth_b,
                                                          depth_c));
            if (psel && penable && pwrite && pready)
            begin
                case (zsb_reg_t'(paddr[APB_ADDR_W-1:2]))
                    REG_DEPTH_MIN:    near_bound   <= pwdata[DEPTH_W-1:0];
                    REG_DEPTH_MAX:    far_bound    <= pwdata[DEPTH_W-1:0];
                    REG_BUCKET_COUNT: bucket_total <= pwdata[SIZE_W-1:0];
                    REG_DEPTH_RULE:   rule_sel     <= pwdata[RULE_W-1:0];
                    default: ;
                endcase
            end
            words_waiting <= expected_buckets.size();
        end
    end

endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// Z-sort bucket select: testbench top
// Drives primitives into the bucket selector under a series of register
// settings, from the reset values through full-span, narrow, reversed and
// random depth bounds, with every depth rule and bucket counts from one to
// the maximum. Both word channels idle and stall at random in turn. The
// bucket checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
    import zsb_pkg::*;

    localparam int     QUIET_LIMIT     = 2000;
    localparam int     PHASES          = 12;
    localparam int     PRIMS_PER_PHASE = 128;
    localparam longint DEPTH_HI        = 64'sd2147483647;
    localparam longint DEPTH_LO        = -64'sd2147483648;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [DEPTH_W-1:0] da;
        logic [DEPTH_W-1:0] db;
        logic [DEPTH_W-1:0] dc;
    } prim_t;

    logic                         clk          = 1'b0;
    logic                         rst_n        = 1'b0;
    logic                         psel         = 1'b0;
    logic                         penable      = 1'b0;
    logic                         pwrite       = 1'b0;
    logic        [APB_ADDR_W-1:0] paddr        = '0;
    logic        [APB_DATA_W-1:0] pwdata       = '0;
    logic        [APB_DATA_W-1:0] prdata;
    logic                         pready;
    logic                         push         = 1'b0;
    logic                         full;
    logic        [KIND_W-1:0]     prim_kind    = '0;
    logic signed [DEPTH_W-1:0]    depth_a      = '0;
    logic signed [DEPTH_W-1:0]    depth_b      = '0;
    logic signed [DEPTH_W-1:0]    depth_c      = '0;
    logic                         empty;
    logic                         pop          = 1'b0;
    logic        [IDX_W-1:0]      bucket_index;

    int                           fail_count;
    int                           words_waiting;
    int                           quiet_cycles = 0;
    int                           send_idle_pct = 0;
    int                           recv_stall_pct = 0;
    logic signed [DEPTH_W-1:0]    near_cfg     = '0;
    logic signed [DEPTH_W-1:0]    far_cfg      = '0;

    z_sort_bucket_select i_dut (.*);

    zsb_bucket_checker i_checker (.*);

    initial forever #1 clk = ~clk;

    always @(posedge clk)
        pop <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic set_pressure(input int mode);
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
            default: begin send_idle_pct = 9; recv_stall_pct = 9; end
        endcase
    endtask

    task automatic write_config(input logic [DEPTH_W-1:0] zlo, input logic [DEPTH_W-1:0] zhi,
                                input logic [SIZE_W-1:0] count,
                                input logic [RULE_W-1:0] rule);
        zsb_reg_t                r;
        logic [APB_DATA_W-1:0]   v;
        for (int i = 0; i < 4; i++)
        begin
            r = zsb_reg_t'(i);
            case (r)
                REG_DEPTH_MIN:    v = zlo;
                REG_DEPTH_MAX:    v = zhi;
                REG_BUCKET_COUNT: v = APB_DATA_W'(count);
                REG_DEPTH_RULE:   v = APB_DATA_W'(rule);
                default:          v = '0;
            endcase
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= {r, 2'b00};
            pwdata  <= v;
            @(posedge clk);
            penable <= 1'b1;
            @(posedge clk);
        end
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        near_cfg  = zlo;
        far_cfg   = zhi;
    endtask

    task automatic send_prim(input prim_t p);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push      <= 1'b1;
        prim_kind <= p.kind;
        depth_a   <= p.da;
        depth_b   <= p.db;
        depth_c   <= p.dc;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    task automatic drain();
        push <= 1'b0;
        do
            @(posedge clk);
        while (words_waiting != 0);
        repeat (4) @(posedge clk);
    endtask

    function automatic prim_t make_prim(input logic [KIND_W-1:0] kind,
                                        input logic [DEPTH_W-1:0] a,
                                        input logic [DEPTH_W-1:0] b,
                                        input logic [DEPTH_W-1:0] c);
        prim_t p;
        p.kind = kind;
        p.da   = a;
        p.db   = b;
        p.dc   = c;
        return p;
    endfunction

    // Most depths fall in and just around the configured bounds so that the
    // buckets spread; the rest are full-range or extreme values.
    function automatic logic [DEPTH_W-1:0] pick_depth();
        longint     lo, hi, width, v;
        logic [63:0] r;
        lo = near_cfg;
        hi = far_cfg;
        if (hi - lo < 4096)
        begin
            lo = lo - 65536;
            hi = lo + 131072;
        end
        width = hi - lo;
        lo    = lo - width / 8;
        width = width + width / 4 + 1;
        case ($urandom_range(9))
            0: return $urandom;
            1: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
            default:
            begin
                r = {$urandom, $urandom};
                v = lo + longint'(r % width);
                if (v > DEPTH_HI) v = DEPTH_HI;
                if (v < DEPTH_LO) v = DEPTH_LO;
                return v[DEPTH_W-1:0];
            end
        endcase
    endfunction

    initial
    begin
        logic [DEPTH_W-1:0] zlo, zhi;
        logic [SIZE_W-1:0]  count;
        logic [RULE_W-1:0]  rule;
        longint             hi_l;
        logic [KIND_W-1:0]  kind;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: zero-width depth span, 256 buckets, averaging.
        send_prim(make_prim(KIND_POINT, 32'h0000_0000, 32'h7fff_ffff, 32'h7fff_ffff));
        send_prim(make_prim(KIND_POINT, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000));
        send_prim(make_prim(KIND_POINT, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000));
        send_prim(make_prim(KIND_POINT, 32'd65, 32'h0, 32'h0));
        send_prim(make_prim(KIND_POINT, 32'd66, 32'h0, 32'h0));
        send_prim(make_prim(KIND_LINE, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000));
        send_prim(make_prim(KIND_LINE, 32'hffff_ffff, 32'h0000_0000, 32'h7fff_ffff));
        send_prim(make_prim(KIND_LINE, 32'h8000_0000, 32'h7fff_ffff, 32'h0));
        send_prim(make_prim(KIND_TRI, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
        send_prim(make_prim(KIND_TRI, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        send_prim(make_prim(KIND_TRI, 32'hffff_ffff, 32'hffff_ffff, 32'h0000_0001));
        send_prim(make_prim(KIND_TRI, 32'd196608, 32'h0, 32'h0));
        send_prim(make_prim(KIND_TRI, 32'd200, 32'h0, 32'h0));
        drain();

        write_config(32'h8000_0000, 32'h7fff_ffff, 13'd4096, RULE_MIN);
        send_prim(make_prim(KIND_LINE, 32'h7fff_ffff, 32'h8000_0000, 32'h0));
        send_prim(make_prim(KIND_TRI, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
        send_prim(make_prim(KIND_POINT, 32'h0, 32'h8000_0000, 32'h8000_0000));
        drain();
        write_config(32'h8000_0000, 32'h7fff_ffff, 13'd4096, RULE_MAX);
        send_prim(make_prim(KIND_LINE, 32'h7fff_ffff, 32'h8000_0000, 32'h0));
        send_prim(make_prim(KIND_TRI, 32'h8000_0000, 32'h8000_0000, 32'h0));
        drain();
        write_config(32'h8000_0000, 32'h7fff_ffff, 13'd1, RULE_AVG);
        send_prim(make_prim(KIND_POINT, 32'h7fff_ffff, 32'h0, 32'h0));
        drain();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph % 3)
                0:       rule = RULE_AVG;
                1:       rule = RULE_MIN;
                default: rule = RULE_MAX;
            endcase
            case (ph)
                0: begin zlo = 32'h8000_0000; zhi = 32'h7fff_ffff; count = 13'd4096; end
                1: begin zlo = 32'd0; zhi = 32'd65; count = 13'd4096; end
                2: begin zlo = -32'sd100; zhi = -32'sd34; count = 13'd1; end
                3: begin zlo = 32'h7fff_ffff; zhi = 32'h8000_0000; count = 13'd4096; end
                default:
                begin
                    zlo  = $urandom;
                    hi_l = longint'($signed(zlo)) + longint'($urandom >> $urandom_range(31));
                    if (hi_l > DEPTH_HI)
                        hi_l = DEPTH_HI;
                    zhi = hi_l[DEPTH_W-1:0];
                    case ($urandom_range(3))
                        0:       count = SIZE_W'($urandom_range(16, 1));
                        1:       count = SIZE_W'($urandom_range(4096, 1));
                        2:       count = 13'd4096;
                        default: count = BUCKET_COUNT_RESET;
                    endcase
                end
            endcase
            write_config(zlo, zhi, count, rule);
            set_pressure(ph % 4);
            for (int n = 0; n < PRIMS_PER_PHASE; n++)
            begin
                kind = KIND_W'($urandom_range(2));
                send_prim(make_prim(kind, pick_depth(), pick_depth(), pick_depth()));
            end
            drain();
        end

        repeat (30) @(posedge clk);
        if (fail_count == 0 && words_waiting == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/zsb_pkg.sv
hw/rtl/zsb_queue.sv
hw/rtl/zsb_front.sv
hw/rtl/zsb_back.sv
hw/rtl/z_sort_bucket_select.sv
bench/zsb_bucket_checker.sv
bench/tb.sv
